// ----- hdl/obcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obcs_pkg
// shared types and constants of the oriented bilinear crop scaler
// ----------------------------------------------------------------------------
package obcs_pkg;

    localparam int unsigned CfgIdxBits = 3;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_SRC_W  = 3'd0,
        CFG_SRC_H  = 3'd1,
        CFG_PITCH  = 3'd2,
        CFG_ORIENT = 3'd3,
        CFG_CROP_L = 3'd4,
        CFG_CROP_T = 3'd5,
        CFG_CROP_W = 3'd6,
        CFG_CROP_H = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    localparam logic [3:0] ORIENT_MIR_H   = 4'd2;
    localparam logic [3:0] ORIENT_ROT_180 = 4'd3;
    localparam logic [3:0] ORIENT_MIR_V   = 4'd4;
    localparam logic [3:0] ORIENT_TRANSP  = 4'd5;
    localparam logic [3:0] ORIENT_ROT_90  = 4'd6;
    localparam logic [3:0] ORIENT_TRANSV  = 4'd7;
    localparam logic [3:0] ORIENT_ROT_270 = 4'd8;

    localparam logic [16:0] HALF_PIXEL = 17'd32768;
    localparam logic [16:0] ROUND_HALF = 17'd32768;

    typedef struct packed {
        logic [15:0] pixel;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        fault;
    } t_result;

endpackage : obcs_pkg
`default_nettype wire

// ----- hdl/obcs_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obcs_in_if
// input word channel: pixel writes and sample requests
// ----------------------------------------------------------------------------
interface obcs_in_if #(
    parameter int unsigned ADDR_W = 20
);
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] store_address;
    logic [15:0]       write_pixel;
    logic [9:0]        out_col;
    logic [9:0]        out_row;

    modport source (output valid, opcode, store_address, write_pixel, out_col, out_row,
                    input ready);
    modport sink (input valid, opcode, store_address, write_pixel, out_col, out_row,
                  output ready);
endinterface : obcs_in_if
`default_nettype wire

// ----- hdl/obcs_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obcs_out_if
// result word channel: blended pixels
// ----------------------------------------------------------------------------
interface obcs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sampled_pixel;
    logic [9:0]  result_col;
    logic [9:0]  result_row;
    logic        address_fault;

    modport source (output valid, sampled_pixel, result_col, result_row, address_fault,
                    input ready);
    modport sink (input valid, sampled_pixel, result_col, result_row, address_fault,
                  output ready);
endinterface : obcs_out_if
`default_nettype wire

// ----- hdl/obcs_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obcs_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface obcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface : obcs_cfg_if
`default_nettype wire

// ----- hdl/oriented_bilinear_crop_scaler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_bilinear_crop_scaler
// maps output pixels through crop and orientation, blends four RGB565 neighbours
// ----------------------------------------------------------------------------
//  channel   dir  words
//  i_in      in   pixel write (opcode 0) or sample request (opcode 1)
//  o_out     out  one blended pixel per sample request
//  i_cfg     in   register write, index 0..7
//
//  a pixel write is held off while a sample waits for its reads; a sample reads
//  four neighbours through the single memory port, and a gap counter spaces samples.
//  a result passes C1..C4, the fetch, the neighbour collect, B1 and B2; at most two
//  samples sit between accept and handoff, so one may enter before the last leaves.
//  reset clears control and registers; the frame memory has no reset; samples
//  are held off on leaving reset and after a register write; output stalls back-pressure
//  through a 2-entry skid fifo.
// ----------------------------------------------------------------------------
module oriented_bilinear_crop_scaler
    import obcs_pkg::*;
#(
    parameter int unsigned OUT_WIDTH       = 1024,
    parameter int unsigned OUT_HEIGHT      = 600,
    parameter int unsigned STORE_ADDR_BITS = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    obcs_in_if.sink     i_in,
    obcs_out_if.source  o_out,
    obcs_cfg_if.sink    i_cfg
);
    localparam int unsigned AW    = STORE_ADDR_BITS;
    localparam int unsigned DEPTH = 1 << AW;
    localparam logic [29:0] SU_K  = 30'(((64'd1 << 29) + OUT_WIDTH - 1) / OUT_WIDTH);
    localparam logic [29:0] SV_K  = 30'(((64'd1 << 29) + OUT_HEIGHT - 1) / OUT_HEIGHT);

    // ---------------- configuration ----------------
    logic [12:0] r_src_w, r_src_h, r_pitch, r_crop_w, r_crop_h;
    logic [11:0] r_crop_l, r_crop_t;
    logic [3:0]  r_orient;
    logic        r_cfg_hold;    // holds samples off while the registered step sizes follow a write

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= 13'd1024;
            r_src_h  <= 13'd600;
            r_pitch  <= 13'd1024;
            r_orient <= 4'd1;
            r_crop_l <= '0;
            r_crop_t <= '0;
            r_crop_w <= 13'd1024;
            r_crop_h <= 13'd600;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SRC_W:  r_src_w  <= i_cfg.data;
                CFG_SRC_H:  r_src_h  <= i_cfg.data;
                CFG_PITCH:  r_pitch  <= i_cfg.data;
                CFG_ORIENT: r_orient <= i_cfg.data[3:0];
                CFG_CROP_L: r_crop_l <= i_cfg.data[11:0];
                CFG_CROP_T: r_crop_t <= i_cfg.data[11:0];
                CFG_CROP_W: r_crop_w <= i_cfg.data;
                CFG_CROP_H: r_crop_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg_hold <= 1'b1;
        else r_cfg_hold <= i_cfg.valid && i_cfg.ready;
    end

    // step sizes: floor(crop*65536/OUT) via reciprocal then exact correction
    logic [29:0] r_su, r_sv;
    logic [42:0] su_prod, sv_prod;
    logic [29:0] su_est, sv_est;
    logic [29:0] su_fix, sv_fix;
    logic [46:0] su_chk, sv_chk;

    always_comb begin
        su_prod = 43'(r_crop_w) * 43'(SU_K);
        sv_prod = 43'(r_crop_h) * 43'(SV_K);
        su_est  = 30'(su_prod >> 13);
        sv_est  = 30'(sv_prod >> 13);
        su_chk  = 47'(su_est) * 47'(OUT_WIDTH);
        sv_chk  = 47'(sv_est) * 47'(OUT_HEIGHT);
        su_fix  = (su_chk > {18'd0, r_crop_w, 16'd0}) ? su_est - 30'd1 : su_est;
        sv_fix  = (sv_chk > {18'd0, r_crop_h, 16'd0}) ? sv_est - 30'd1 : sv_est;
    end

    always_ff @(posedge i_clk) begin
        r_su <= su_fix;
        r_sv <= sv_fix;
    end

    // ---------------- front end sequencer ----------------
    // stage S0 accepts; writes go straight to memory when the port is free
    logic [15:0] mem [DEPTH];
    logic [15:0] r_rd;

    logic [1:0]  r_fcnt;       // neighbour fetch counter
    logic        r_fbusy;
    logic [AW-1:0] r_fa [4];
    logic        r_ffault;
    logic [9:0]  r_fcol, r_frow;
    logic [7:0]  r_ffx, r_ffy;

    // coordinate pipe (4 stages) valid bits
    logic        r_c1v, r_c2v, r_c3v, r_c4v;
    logic        pipe_room;
    logic [2:0]  r_inflight;    // samples accepted but not yet in fifo
    logic [1:0]  r_fifo_cnt;
    logic        in_fire, in_sample, in_write;

    // after a sample, r_gap spaces the next; a write waits until earlier samples have read
    logic [1:0] r_gap;
    assign pipe_room = (32'(r_inflight) + 32'(r_fifo_cnt)) < 32'd2;
    assign i_in.ready = (i_in.opcode == OP_SAMPLE)
                        ? (r_gap == 2'd0 && pipe_room && !r_cfg_hold)
                        : !(r_fbusy || r_c1v || r_c2v || r_c3v || r_c4v);
    assign in_fire   = i_in.valid && i_in.ready;
    assign in_sample = in_fire && (i_in.opcode == OP_SAMPLE);
    assign in_write  = in_fire && (i_in.opcode == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gap <= '0;
        else if (in_sample) r_gap <= 2'd3;
        else if (r_gap != 2'd0) r_gap <= r_gap - 2'd1;
    end

    // C1: products su*col, sv*row
    logic [9:0]  r_c1col, r_c1row;
    logic [39:0] r_c1pu, r_c1pv;
    logic [29:0] r_c1su, r_c1sv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c1v <= 1'b0;
        else r_c1v <= in_sample;
        r_c1col <= i_in.out_col;
        r_c1row <= i_in.out_row;
        r_c1pu  <= 40'(r_su) * 40'(i_in.out_col);
        r_c1pv  <= 40'(r_sv) * 40'(i_in.out_row);
        r_c1su  <= r_su;
        r_c1sv  <= r_sv;
    end

    // C2: u, v (signed)
    logic signed [42:0] r_u, r_v;
    logic [9:0] r_c2col, r_c2row;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c2v <= 1'b0;
        else r_c2v <= r_c1v;
        r_u <= $signed({15'd0, r_crop_l, 16'd0}) + $signed({3'd0, r_c1pu})
             + $signed({14'd0, r_c1su[29:1]}) - $signed({26'd0, HALF_PIXEL});
        r_v <= $signed({15'd0, r_crop_t, 16'd0}) + $signed({3'd0, r_c1pv})
             + $signed({14'd0, r_c1sv[29:1]}) - $signed({26'd0, HALF_PIXEL});
        r_c2col <= r_c1col;
        r_c2row <= r_c1row;
    end

    // C3: orientation and clamp
    logic [12:0] w_eff, h_eff;
    logic signed [42:0] wm, hm, ox, oy, cx, cy;
    assign w_eff = (r_src_w == 13'd0) ? 13'd1 : r_src_w;
    assign h_eff = (r_src_h == 13'd0) ? 13'd1 : r_src_h;
    assign wm = $signed({14'd0, w_eff - 13'd1, 16'd0});
    assign hm = $signed({14'd0, h_eff - 13'd1, 16'd0});
    always_comb begin
        case (r_orient)
            ORIENT_MIR_H:   begin ox = wm - r_u; oy = r_v;      end
            ORIENT_ROT_180: begin ox = wm - r_u; oy = hm - r_v; end
            ORIENT_MIR_V:   begin ox = r_u;      oy = hm - r_v; end
            ORIENT_TRANSP:  begin ox = r_v;      oy = r_u;      end
            ORIENT_ROT_90:  begin ox = r_v;      oy = hm - r_u; end
            ORIENT_TRANSV:  begin ox = wm - r_v; oy = hm - r_u; end
            ORIENT_ROT_270: begin ox = wm - r_v; oy = r_u;      end
            default:        begin ox = r_u;      oy = r_v;      end
        endcase
        cx = (ox < 0) ? '0 : ((ox > wm) ? wm : ox);
        cy = (oy < 0) ? '0 : ((oy > hm) ? hm : oy);
    end

    logic [12:0] r_x0, r_y0, r_x1, r_y1;
    logic [7:0]  r_fx, r_fy;
    logic [9:0]  r_c3col, r_c3row;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c3v <= 1'b0;
        else r_c3v <= r_c2v;
        r_x0 <= cx[28:16];
        r_y0 <= cy[28:16];
        r_x1 <= (cx[28:16] + 13'd1 < w_eff) ? cx[28:16] + 13'd1 : cx[28:16];
        r_y1 <= (cy[28:16] + 13'd1 < h_eff) ? cy[28:16] + 13'd1 : cy[28:16];
        r_fx <= cx[15:8];
        r_fy <= cy[15:8];
        r_c3col <= r_c2col;
        r_c3row <= r_c2row;
    end

    // C4: row bases y*pitch
    logic [25:0] r_b0, r_b1;
    logic [12:0] r_c4x0, r_c4x1;
    logic [7:0]  r_c4fx, r_c4fy;
    logic [9:0]  r_c4col, r_c4row;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c4v <= 1'b0;
        else r_c4v <= r_c3v;
        r_b0 <= 26'(r_y0) * 26'(r_pitch);
        r_b1 <= 26'(r_y1) * 26'(r_pitch);
        r_c4x0 <= r_x0; r_c4x1 <= r_x1;
        r_c4fx <= r_fx; r_c4fy <= r_fy;
        r_c4col <= r_c3col; r_c4row <= r_c3row;
    end

    // C5: neighbour addresses and fault, load into fetch sequencer
    logic [26:0] a00, a10, a01, a11;
    logic        c5_fault;
    assign a00 = 27'(r_b0) + 27'(r_c4x0);
    assign a10 = 27'(r_b0) + 27'(r_c4x1);
    assign a01 = 27'(r_b1) + 27'(r_c4x0);
    assign a11 = 27'(r_b1) + 27'(r_c4x1);
    assign c5_fault = (a00 >= 27'(DEPTH)) || (a10 >= 27'(DEPTH))
                   || (a01 >= 27'(DEPTH)) || (a11 >= 27'(DEPTH));

    // fetch: 4 reads on the one port
    logic          fetch_rd;
    logic [AW-1:0] rd_addr;
    logic          r_lastrd, r_rdv;
    assign fetch_rd = r_fbusy && !r_ffault;
    assign rd_addr  = r_fa[r_fcnt];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fbusy <= 1'b0;
            r_fcnt  <= '0;
        end else if (r_c4v) begin
            r_fbusy <= 1'b1;
            r_fcnt  <= '0;
        end else if (r_fbusy) begin
            r_fcnt <= r_fcnt + 2'd1;
            if (r_fcnt == 2'd3) r_fbusy <= 1'b0;
        end
        if (r_c4v) begin
            r_fa[0]  <= a00[AW-1:0];
            r_fa[1]  <= a10[AW-1:0];
            r_fa[2]  <= a01[AW-1:0];
            r_fa[3]  <= a11[AW-1:0];
            r_ffault <= c5_fault;
            r_fcol   <= r_c4col;
            r_frow   <= r_c4row;
            r_ffx    <= r_c4fx;
            r_ffy    <= r_c4fy;
        end
    end

    // single-port frame memory
    logic [AW-1:0] wr_addr;
    assign wr_addr = AW'(i_in.store_address);

    always_ff @(posedge i_clk) begin
        if (in_write && (32'(i_in.store_address) < 32'(DEPTH)))
            mem[wr_addr] <= i_in.write_pixel;
        if (fetch_rd)
            r_rd <= mem[rd_addr];
    end

    // collect neighbours
    logic [1:0]  r_rdi;
    logic [15:0] r_p [3];
    logic        r_gv;
    logic        r_gfault;
    logic [15:0] r_g00, r_g10, r_g01, r_g11;
    logic [7:0]  r_gfx, r_gfy;
    logic [9:0]  r_gcol, r_grow;
    logic        r_lfault;
    logic [7:0]  r_lfx, r_lfy;
    logic [9:0]  r_lcol, r_lrow;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdv <= 1'b0;
            r_lastrd <= 1'b0;
            r_gv <= 1'b0;
        end else begin
            r_rdv    <= r_fbusy;
            r_lastrd <= r_fbusy && (r_fcnt == 2'd3);
            r_gv     <= r_rdv && r_lastrd;
        end
        r_rdi <= r_fcnt;
        // keep the tags of the last read, the next sample may reload the sequencer
        if (r_fbusy && (r_fcnt == 2'd3)) begin
            r_lfault <= r_ffault;
            r_lfx <= r_ffx; r_lfy <= r_ffy;
            r_lcol <= r_fcol; r_lrow <= r_frow;
        end
        if (r_rdv && !r_lastrd) r_p[r_rdi] <= r_rd;
        if (r_rdv && r_lastrd) begin
            r_g00 <= r_p[0]; r_g10 <= r_p[1]; r_g01 <= r_p[2]; r_g11 <= r_rd;
            r_gfault <= r_lfault;
            r_gfx <= r_lfx; r_gfy <= r_lfy;
            r_gcol <= r_lcol; r_grow <= r_lrow;
        end
    end

    // blend B1: weights
    logic        r_b1v, r_b2v;
    logic [16:0] r_w00, r_w10, r_w01, r_w11;
    logic [15:0] r_h00, r_h10, r_h01, r_h11;
    logic        r_b1fault;
    logic [9:0]  r_b1col, r_b1row;
    logic [8:0]  ifx, ify;
    assign ifx = 9'd256 - 9'(r_gfx);
    assign ify = 9'd256 - 9'(r_gfy);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b1v <= 1'b0;
        else r_b1v <= r_gv;
        r_w00 <= 17'(ifx) * 17'(ify);
        r_w10 <= 17'(r_gfx) * 17'(ify);
        r_w01 <= 17'(ifx) * 17'(r_gfy);
        r_w11 <= 17'(r_gfx) * 17'(r_gfy);
        r_h00 <= r_g00; r_h10 <= r_g10; r_h01 <= r_g01; r_h11 <= r_g11;
        r_b1fault <= r_gfault;
        r_b1col <= r_gcol; r_b1row <= r_grow;
    end

    // blend B2: sums of products per channel
    function automatic logic [22:0] blend(input logic [5:0] a, b, c, d,
                                          input logic [16:0] wa, wb, wc, wd);
        logic [23:0] s;
        s = 24'(a) * 24'(wa) + 24'(b) * 24'(wb) + 24'(c) * 24'(wc)
          + 24'(d) * 24'(wd) + 24'(ROUND_HALF);
        return s[23:1];
    endfunction

    logic [22:0] sr, sg, sb;
    assign sr = blend({1'b0, r_h00[15:11]}, {1'b0, r_h10[15:11]}, {1'b0, r_h01[15:11]},
                      {1'b0, r_h11[15:11]}, r_w00, r_w10, r_w01, r_w11);
    assign sg = blend(r_h00[10:5], r_h10[10:5], r_h01[10:5], r_h11[10:5],
                      r_w00, r_w10, r_w01, r_w11);
    assign sb = blend({1'b0, r_h00[4:0]}, {1'b0, r_h10[4:0]}, {1'b0, r_h01[4:0]},
                      {1'b0, r_h11[4:0]}, r_w00, r_w10, r_w01, r_w11);

    t_result r_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b2v <= 1'b0;
        else r_b2v <= r_b1v;
        r_res.pixel <= r_b1fault ? 16'd0 : {sr[19:15], sg[20:15], sb[19:15]};
        r_res.col   <= r_b1col;
        r_res.row   <= r_b1row;
        r_res.fault <= r_b1fault;
    end

    // output skid fifo, 2 entries
    t_result     r_q [2];
    logic        r_wp, r_rp;
    logic        out_fire;
    assign out_fire = o_out.valid && o_out.ready;
    assign o_out.valid         = (r_fifo_cnt != 2'd0);
    assign o_out.sampled_pixel = r_q[r_rp].pixel;
    assign o_out.result_col    = r_q[r_rp].col;
    assign o_out.result_row    = r_q[r_rp].row;
    assign o_out.address_fault = r_q[r_rp].fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_fifo_cnt <= '0;
            r_inflight <= '0;
        end else begin
            if (r_b2v) r_wp <= !r_wp;
            if (out_fire) r_rp <= !r_rp;
            r_fifo_cnt <= r_fifo_cnt + 2'(r_b2v) - 2'(out_fire);
            r_inflight <= r_inflight + 3'(in_sample) - 3'(r_b2v);
        end
        if (r_b2v) r_q[r_wp] <= r_res;
    end

    // ---------------- checks ----------------
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= 2'd2) else $error("result fifo overflow");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c4v |-> !r_fbusy || (r_fcnt == 2'd3)) else $error("fetch overlap");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_write |-> !fetch_rd) else $error("write collides with fetch");
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_inflight) + 32'(r_fifo_cnt)) <= 32'd2) else $error("credit lost");

endmodule : oriented_bilinear_crop_scaler
`default_nettype wire
